// ===== hw/rtl/man_page_deformatter_defines.svh =====
// ----------------------------------------------------------------------------
// man_page_deformatter defines
// assertion macros used by the checker
// ----------------------------------------------------------------------------
`ifndef MAN_PAGE_DEFORMATTER_DEFINES_SVH
`define MAN_PAGE_DEFORMATTER_DEFINES_SVH

// same-cycle implication
`define MPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mpd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpd_pkg
// shared types, constants and byte classes of the man page deformatter
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int RUN_MAX = 4;
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
  localparam int RUN_IDX_W = $clog2(RUN_MAX);

  // output bytes caused by one input item
  typedef struct packed {
    logic [RUN_CNT_W-1:0]     count;
    logic [RUN_MAX-1:0][7:0]  bytes;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_letter(b) || ((b >= 8'h30) && (b <= 8'h39));
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    logic r;
    unique case (b)
      8'h5b, 8'h5d, 8'h3c, 8'h3e, 8'h7b, 8'h7d,
      8'h5c, 8'h2f, 8'h5e, 8'h24, 8'h40: r = 1'b1;
      default:                           r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/man_page_deformatter.sv =====
// ----------------------------------------------------------------------------
// man_page_deformatter
// brackets the non-translatable parts of man page text and escapes specials
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the run queue has room; the byte is
// classified and its whole run of zero to four output bytes is built in that
// cycle. The output serializer sends one byte per cycle while out_stall is
// low, with up to QueueDepth runs buffered; the first output byte passes
// through the run queue and then the output register before it is valid.
module man_page_deformatter #(
  parameter int QueueDepth = mpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import mpd_pkg::*;

  run_t   push_run;
  run_t   head_run;
  qstat_t q_stat;
  logic   push;
  logic   pop;

  mpd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .q_stat       (q_stat),
    .push         (push),
    .push_run     (push_run)
  );

  mpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head_run (head_run),
    .q_stat   (q_stat)
  );

  mpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_run    (head_run),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

// ===== hw/rtl/mpd_front.sv =====
// ----------------------------------------------------------------------------
// mpd_front
// scanner: takes one byte per cycle while the run queue has room, tracks the scan
// mode and builds the run of output bytes that the byte causes
// ----------------------------------------------------------------------------
module mpd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          end_of_input,
  input  mpd_pkg::qstat_t q_stat,
  output logic          push,
  output mpd_pkg::run_t push_run
);
  import mpd_pkg::*;

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_KEYWORD = 3'd1;
  localparam logic [2:0] MODE_NLRUN   = 3'd2;
  localparam logic [2:0] MODE_DASH    = 3'd3;
  localparam logic [2:0] MODE_OPTION  = 3'd4;

  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_NL     = 8'h0a;

  logic [2:0]           scan_mode, scan_mode_next;
  logic                 at_line_start, at_line_start_next;
  logic                 bracket_open, bracket_open_next;
  logic                 disp;
  logic [RUN_CNT_W-1:0] cnt;
  logic [RUN_MAX-1:0][7:0] bytes;
  logic                 accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    scan_mode_next     = scan_mode;
    at_line_start_next = at_line_start;
    bracket_open_next  = bracket_open;
    disp  = 1'b0;
    cnt   = '0;
    bytes = '0;
    if (end_of_input) begin
      unique case (scan_mode)
        MODE_KEYWORD, MODE_NLRUN, MODE_OPTION: begin
          bytes[cnt[RUN_IDX_W-1:0]] = CH_RBRACK; cnt = cnt + 1'b1;
        end
        MODE_DASH: begin
          if (bracket_open) begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_RBRACK; cnt = cnt + 1'b1;
          end
          bytes[cnt[RUN_IDX_W-1:0]] = CH_DASH; cnt = cnt + 1'b1;
        end
        default: begin
          if (bracket_open) begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_RBRACK; cnt = cnt + 1'b1;
          end
        end
      endcase
      scan_mode_next     = MODE_NORMAL;
      at_line_start_next = 1'b1;
      bracket_open_next  = 1'b0;
    end else begin
      unique case (scan_mode)
        MODE_KEYWORD: begin
          if (is_letter(data_byte)) begin
            bytes[cnt[RUN_IDX_W-1:0]] = data_byte; cnt = cnt + 1'b1;
          end else begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_RBRACK; cnt = cnt + 1'b1;
            bracket_open_next  = 1'b0;
            at_line_start_next = 1'b0;
            disp = 1'b1;
          end
        end
        MODE_NLRUN: begin
          if (data_byte == CH_NL) begin
            bytes[cnt[RUN_IDX_W-1:0]] = data_byte; cnt = cnt + 1'b1;
          end else begin
            disp = 1'b1;
          end
        end
        MODE_DASH: begin
          at_line_start_next = 1'b0;
          if (is_alnum(data_byte)) begin
            if (!bracket_open_next) begin
              bytes[cnt[RUN_IDX_W-1:0]] = CH_LBRACK; cnt = cnt + 1'b1;
              bracket_open_next = 1'b1;
            end
            bytes[cnt[RUN_IDX_W-1:0]] = CH_DASH; cnt = cnt + 1'b1;
            bytes[cnt[RUN_IDX_W-1:0]] = data_byte; cnt = cnt + 1'b1;
            scan_mode_next = MODE_OPTION;
          end else begin
            if (bracket_open_next) begin
              bytes[cnt[RUN_IDX_W-1:0]] = CH_RBRACK; cnt = cnt + 1'b1;
              bracket_open_next = 1'b0;
            end
            bytes[cnt[RUN_IDX_W-1:0]] = CH_DASH; cnt = cnt + 1'b1;
            disp = 1'b1;
          end
        end
        MODE_OPTION: begin
          if (is_alnum(data_byte)) begin
            bytes[cnt[RUN_IDX_W-1:0]] = data_byte; cnt = cnt + 1'b1;
          end else begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_RBRACK; cnt = cnt + 1'b1;
            bracket_open_next = 1'b0;
            disp = 1'b1;
          end
        end
        default: begin
          disp = 1'b1;
        end
      endcase

      // normal text handling of the byte
      if (disp) begin
        scan_mode_next = MODE_NORMAL;
        if (at_line_start_next && (data_byte == CH_DOT)) begin
          if (!bracket_open_next) begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_LBRACK; cnt = cnt + 1'b1;
            bracket_open_next = 1'b1;
          end
          bytes[cnt[RUN_IDX_W-1:0]] = data_byte; cnt = cnt + 1'b1;
          scan_mode_next = MODE_KEYWORD;
        end else if (data_byte == CH_NL) begin
          if (!bracket_open_next) begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_LBRACK; cnt = cnt + 1'b1;
            bracket_open_next = 1'b1;
          end
          bytes[cnt[RUN_IDX_W-1:0]] = data_byte; cnt = cnt + 1'b1;
          at_line_start_next = 1'b1;
          scan_mode_next = MODE_NLRUN;
        end else if (data_byte == CH_DASH) begin
          scan_mode_next = MODE_DASH;
        end else begin
          if (bracket_open_next) begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_RBRACK; cnt = cnt + 1'b1;
            bracket_open_next = 1'b0;
          end
          if (needs_escape(data_byte)) begin
            bytes[cnt[RUN_IDX_W-1:0]] = CH_BSLASH; cnt = cnt + 1'b1;
          end
          bytes[cnt[RUN_IDX_W-1:0]] = data_byte; cnt = cnt + 1'b1;
          at_line_start_next = 1'b0;
        end
      end
    end
  end

  assign push           = accept && (cnt != '0);
  assign push_run.count = cnt;
  assign push_run.bytes = bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_NORMAL;
      at_line_start <= 1'b1;
      bracket_open  <= 1'b0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      at_line_start <= at_line_start_next;
      bracket_open  <= bracket_open_next;
    end
  end

endmodule

// ===== hw/rtl/mpd_queue.sv =====
// ----------------------------------------------------------------------------
// mpd_queue
// small fifo of byte runs between the scanner and the output serializer
// ----------------------------------------------------------------------------
module mpd_queue #(
  parameter int Depth = mpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mpd_pkg::run_t push_run,
  input  logic          pop,
  output mpd_pkg::run_t head_run,
  output mpd_pkg::qstat_t q_stat
);
  import mpd_pkg::*;

  localparam int PtrW  = $clog2(Depth);
  localparam int FillW = $clog2(Depth + 1);

  run_t             mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [FillW-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (fill == FillW'(Depth));
  assign q_stat.empty = (fill == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_run     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mpd_back.sv =====
// ----------------------------------------------------------------------------
// mpd_back
// output serializer: sends the bytes of the head run one per transfer and
// marks the final byte of each run
// ----------------------------------------------------------------------------
module mpd_back (
  input  logic            clk,
  input  logic            rst,
  input  mpd_pkg::run_t   head_run,
  input  mpd_pkg::qstat_t q_stat,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);
  import mpd_pkg::*;

  logic [RUN_IDX_W-1:0] idx;
  logic                 load;
  logic                 take;
  logic                 is_last;

  assign load    = !out_valid || !out_stall;
  assign take    = load && !q_stat.empty;
  assign is_last = (RUN_CNT_W'(idx) + 1'b1) == head_run.count;
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte    <= head_run.bytes[idx];
      last_of_run <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_stat.empty;
      if (take) begin
        idx <= is_last ? '0 : idx + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/mpd_checker.sv =====
// ----------------------------------------------------------------------------
// mpd_checker
// port-level checks of the man page deformatter, bound to the top level
// ----------------------------------------------------------------------------
`include "man_page_deformatter_defines.svh"

module mpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] data_byte,
  input logic       end_of_input,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // stalled input holds
  `MPD_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(data_byte) && $stable(end_of_input), "input changed while stalled")

  // stalled output holds
  `MPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last_of_run), "output changed while stalled")

  // full run queue means the output side has a byte waiting
  `MPD_ASSERT_NOW(a_stall_has_output, in_stall, out_valid, "input stalled with no output pending")

  // rest of a run follows without a gap
  `MPD_ASSERT_NEXT(a_run_contiguous, out_valid && !out_stall && !last_of_run, out_valid, "gap inside an output run")

endmodule

bind man_page_deformatter mpd_checker u_mpd_checker (.*);
